FILE: rtl/core/cpu_process_scheduler_unit_defines.svh
// Assertion macros for the process scheduler RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CPU_PROCESS_SCHEDULER_UNIT_DEFINES_SVH
`define CPU_PROCESS_SCHEDULER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CPS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("check failed");
`define CPS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`else
`define CPS_ASSERT_ALWAYS(label, expr)
`define CPS_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

FILE: rtl/core/cps_pkg.sv
// Shared types and codes for the process scheduler.
// No dependencies.
package cps_pkg;

    typedef enum logic [1:0] {
        MODE_FCFS = 2'd0,
        MODE_RR   = 2'd1,
        MODE_SPN  = 2'd2,
        MODE_HRRN = 2'd3
    } t_mode;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic CFG_MODE    = 1'b0;
    localparam logic CFG_QUANTUM = 1'b1;

    localparam logic [11:0] NOW_MAX   = 12'hFFF;
    localparam logic [7:0]  SLICE_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0] arrival;
        logic [7:0] service;
        logic [7:0] used;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEL,
        S_POP,
        S_RUN,
        S_WB,
        S_DONE
    } t_state;

endpackage

FILE: rtl/core/cpu_process_scheduler_unit.sv
// Process scheduler top level: slot table memory, scan sequencer, RR ready queue.
// Depends on cps_pkg and cpu_process_scheduler_unit_defines.svh.
//
// channel   dir  handshake                        payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser command, tdata slot/arrival/service
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata running_slot/idle/finished/all_done
// cfg       in   i_cfg_valid/o_cfg_ready          index 0 mode, 1 quantum
//
// A tick does one slot-table read per cycle during the scan, in RR mode one queue pop per
// cycle, then one read-modify-write of the running slot. No clearing pass after reset.
// Reset (i_rst_n low, synchronous) clears control state; table contents stay undefined.
// Results wait in an output register; the next word is accepted while one waits.
`include "cpu_process_scheduler_unit_defines.svh"

module cpu_process_scheduler_unit #(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // slot[2:0], arrival[10:3], service[18:11]
    input  logic [0:0]  i_s_axis_tuser,   // command[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // running_slot[2:0], idle[3], finished[4], all_done[5]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = CW + 1;

    cps_pkg::t_entry mem [SLOTS];
    cps_pkg::t_entry r_rd;
    logic            mem_we;
    logic [SW-1:0]   mem_wa;
    cps_pkg::t_entry mem_wd;
    logic [SW-1:0]   rd_addr;

    cps_pkg::t_state r_state, n_state;
    cps_pkg::t_mode  r_mode;
    logic [7:0]      r_quantum;
    logic [11:0]     r_now, n_now;
    logic [SW-1:0]   r_cur, n_cur;
    logic            r_busy, n_busy;
    logic [7:0]      r_slice, n_slice;
    logic [SLOTS-1:0] r_inc, n_inc;
    logic [SLOTS-1:0] r_elig, n_elig;
    logic [SLOTS-1:0] r_queued, n_queued;
    logic [SW-1:0]   r_fifo [SLOTS];
    logic [SW-1:0]   n_fifo [SLOTS];
    logic [SW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_cur_ok, n_cur_ok;
    logic            r_have, n_have;
    logic [SW-1:0]   r_best, n_best;
    logic [7:0]      r_best_arr, n_best_arr;
    logic [7:0]      r_best_srv, n_best_srv;
    logic [2:0]      r_run, n_run;
    logic            r_idle, n_idle;
    logic            r_fin, n_fin;
    logic            r_ovalid, n_ovalid;
    logic [7:0]      r_odata, n_odata;

    logic            in_hs;
    logic [SW-1:0]   ld_slot;
    logic            ld_in_range;
    logic [SW-1:0]   p_idx;
    logic            p_elig;
    logic            better;
    logic [12:0]     ni, nb;
    logic [20:0]     prod_i, prod_b;
    logic            push_req;
    logic [SW-1:0]   push_slot;
    logic [TW-1:0]   tail_sum;
    logic [SW-1:0]   tail_idx;
    logic [SW-1:0]   pop_slot;
    logic [7:0]      q_eff;
    logic [7:0]      used1;
    logic            busy_eff;

    assign o_s_axis_tready = (r_state == cps_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    assign in_hs       = i_s_axis_tvalid && o_s_axis_tready;
    assign ld_slot     = SW'(i_s_axis_tdata[2:0]);
    assign ld_in_range = (32'(i_s_axis_tdata[2:0]) < SLOTS);
    assign p_idx       = SW'(r_cnt - CW'(1));
    assign p_elig      = r_inc[p_idx] && ({4'b0, r_rd.arrival} <= r_now);
    assign q_eff       = (r_quantum == 8'd0) ? 8'd1 : r_quantum;
    assign busy_eff    = r_busy && r_cur_ok;
    assign used1       = r_rd.used + 8'd1;
    assign pop_slot    = r_fifo[r_head];

    // exact response-ratio compare by cross multiplication
    assign ni     = {1'b0, r_now - {4'b0, r_rd.arrival}} + {5'b0, r_rd.service};
    assign nb     = {1'b0, r_now - {4'b0, r_best_arr}} + {5'b0, r_best_srv};
    assign prod_i = 21'(ni) * 21'(r_best_srv);
    assign prod_b = 21'(nb) * 21'(r_rd.service);

    always_comb begin
        case (r_mode)
            cps_pkg::MODE_FCFS: better = r_rd.arrival < r_best_arr;
            cps_pkg::MODE_SPN:  better = r_rd.service < r_best_srv;
            default:            better = prod_i > prod_b;
        endcase
    end

    assign tail_sum = TW'(r_head) + TW'(r_count);
    assign tail_idx = (tail_sum >= TW'(SLOTS)) ? SW'(tail_sum - TW'(SLOTS)) : SW'(tail_sum);

    always_comb begin
        n_state    = r_state;
        n_now      = r_now;
        n_cur      = r_cur;
        n_busy     = r_busy;
        n_slice    = r_slice;
        n_inc      = r_inc;
        n_elig     = r_elig;
        n_queued   = r_queued;
        n_fifo     = r_fifo;
        n_head     = r_head;
        n_count    = r_count;
        n_cnt      = r_cnt;
        n_cur_ok   = r_cur_ok;
        n_have     = r_have;
        n_best     = r_best;
        n_best_arr = r_best_arr;
        n_best_srv = r_best_srv;
        n_run      = r_run;
        n_idle     = r_idle;
        n_fin      = r_fin;
        n_ovalid   = r_ovalid;
        n_odata    = r_odata;
        mem_we     = 1'b0;
        mem_wa     = r_cur;
        mem_wd     = r_rd;
        rd_addr    = r_cur;
        push_req   = 1'b0;
        push_slot  = r_cur;

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            cps_pkg::S_IDLE: begin
                if (in_hs) begin
                    n_run  = 3'd0;
                    n_idle = 1'b1;
                    n_fin  = 1'b0;
                    if (i_s_axis_tuser[0] == cps_pkg::CMD_LOAD) begin
                        if (ld_in_range) begin
                            mem_we = 1'b1;
                            mem_wa = ld_slot;
                            mem_wd = '{arrival: i_s_axis_tdata[10:3],
                                       service: i_s_axis_tdata[18:11],
                                       used: 8'd0};
                            n_inc[ld_slot] = (i_s_axis_tdata[18:11] != 8'd0);
                            if (r_busy && r_cur == ld_slot) begin
                                n_busy = 1'b0;
                            end
                        end
                        n_state = cps_pkg::S_DONE;
                    end else begin
                        n_cnt    = '0;
                        n_have   = 1'b0;
                        n_cur_ok = 1'b0;
                        n_elig   = '0;
                        n_state  = cps_pkg::S_SCAN;
                    end
                end
            end
            cps_pkg::S_SCAN: begin
                if (r_cnt < CW'(SLOTS)) begin
                    rd_addr = SW'(r_cnt);
                end
                if (r_cnt != '0 && p_elig) begin
                    n_elig[p_idx] = 1'b1;
                    if (p_idx == r_cur) begin
                        n_cur_ok = 1'b1;
                    end
                    if (r_mode == cps_pkg::MODE_RR) begin
                        if (!(r_busy && p_idx == r_cur)) begin
                            push_req  = 1'b1;
                            push_slot = p_idx;
                        end
                    end else if (!r_have || better) begin
                        n_have     = 1'b1;
                        n_best     = p_idx;
                        n_best_arr = r_rd.arrival;
                        n_best_srv = r_rd.service;
                    end
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(SLOTS)) begin
                    n_state = cps_pkg::S_SEL;
                end
            end
            cps_pkg::S_SEL: begin
                n_busy = busy_eff;
                if (r_mode == cps_pkg::MODE_RR) begin
                    if (busy_eff && r_slice >= q_eff) begin
                        push_req  = 1'b1;
                        push_slot = r_cur;
                        n_busy    = 1'b0;
                        n_state   = cps_pkg::S_POP;
                    end else if (busy_eff) begin
                        n_state = cps_pkg::S_RUN;
                    end else begin
                        n_state = cps_pkg::S_POP;
                    end
                end else begin
                    if (!busy_eff) begin
                        n_slice = 8'd0;
                        if (r_have) begin
                            n_cur  = r_best;
                            n_busy = 1'b1;
                        end
                    end
                    n_state = cps_pkg::S_RUN;
                end
            end
            cps_pkg::S_POP: begin
                if (r_count != '0) begin
                    n_head   = (32'(r_head) == SLOTS - 1) ? '0 : r_head + SW'(1);
                    n_count  = r_count - CW'(1);
                    n_queued[pop_slot] = 1'b0;
                    if (r_elig[pop_slot]) begin
                        n_cur   = pop_slot;
                        n_busy  = 1'b1;
                        n_slice = 8'd0;
                        n_state = cps_pkg::S_RUN;
                    end
                end else begin
                    n_state = cps_pkg::S_RUN;
                end
            end
            cps_pkg::S_RUN: begin
                rd_addr = r_cur;
                if (r_now != cps_pkg::NOW_MAX) begin
                    n_now = r_now + 12'd1;
                end
                n_state = r_busy ? cps_pkg::S_WB : cps_pkg::S_DONE;
            end
            cps_pkg::S_WB: begin
                mem_we = 1'b1;
                mem_wa = r_cur;
                mem_wd = '{arrival: r_rd.arrival, service: r_rd.service, used: used1};
                if (r_slice != cps_pkg::SLICE_MAX) begin
                    n_slice = r_slice + 8'd1;
                end
                n_run  = 3'(r_cur);
                n_idle = 1'b0;
                if (used1 >= r_rd.service) begin
                    n_fin        = 1'b1;
                    n_busy       = 1'b0;
                    n_inc[r_cur] = 1'b0;
                end
                n_state = cps_pkg::S_DONE;
            end
            cps_pkg::S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {2'b00, ~|r_inc, r_fin, r_idle, r_run};
                    n_state  = cps_pkg::S_IDLE;
                end
            end
            default: n_state = cps_pkg::S_IDLE;
        endcase

        // duplicate and overflow pushes are dropped
        if (push_req && !r_queued[push_slot] && r_count < CW'(SLOTS)) begin
            n_fifo[tail_idx]    = push_slot;
            n_queued[push_slot] = 1'b1;
            n_count             = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= cps_pkg::MODE_FCFS;
            r_quantum <= 8'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == cps_pkg::CFG_MODE) begin
                r_mode <= cps_pkg::t_mode'(i_cfg_data[1:0]);
            end else if (i_cfg_index == cps_pkg::CFG_QUANTUM) begin
                r_quantum <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now    <= '0;
            r_cur    <= '0;
            r_busy   <= 1'b0;
            r_slice  <= '0;
            r_inc    <= '0;
            r_queued <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_now    <= n_now;
            r_cur    <= n_cur;
            r_busy   <= n_busy;
            r_slice  <= n_slice;
            r_inc    <= n_inc;
            r_queued <= n_queued;
            r_head   <= n_head;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fifo     <= n_fifo;
        r_elig     <= n_elig;
        r_cnt      <= n_cnt;
        r_cur_ok   <= n_cur_ok;
        r_have     <= n_have;
        r_best     <= n_best;
        r_best_arr <= n_best_arr;
        r_best_srv <= n_best_srv;
        r_run      <= n_run;
        r_idle     <= n_idle;
        r_fin      <= n_fin;
        r_odata    <= n_odata;
    end

    `CPS_ASSERT_ALWAYS(a_count_range, r_count <= CW'(SLOTS))
    `CPS_ASSERT_ALWAYS(a_marks_match_count, $countones(r_queued) == 32'(r_count))
    `CPS_ASSERT_IMPLY(a_busy_has_work, r_busy, r_inc[r_cur])
    `CPS_ASSERT_IMPLY(a_fin_not_idle, r_ovalid && r_odata[4], !r_odata[3])

endmodule

FILE: bench/tb_cpu_process_scheduler_unit.sv
// Self-checking bench for cpu_process_scheduler_unit: random slot loads and ticks under
// all four policies, each result checked against a behavioral scheduler model.
// Depends on cps_pkg and the scheduler RTL only.
`timescale 1ns / 100ps

module tb_cpu_process_scheduler_unit;

    localparam int NSLOT = 8;

    typedef struct {
        logic       cmd;
        logic [2:0] slot;
        logic [7:0] arrival;
        logic [7:0] service;
    } t_sched_cmd;

    typedef struct {
        logic [2:0] run_slot;
        logic       idle;
        logic       finished;
        logic       all_done;
    } t_sched_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;   // slot[2:0], arrival[10:3], service[18:11]
    logic [0:0]  i_s_axis_tuser;   // command[0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;   // running_slot[2:0], idle[3], finished[4], all_done[5]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    cpu_process_scheduler_unit #(.SLOTS(NSLOT)) u_dut (.*);

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // ---------------- scheduler model state ----------------
    cps_pkg::t_mode m_mode;
    logic [7:0] m_quantum;
    logic [7:0] m_arr   [NSLOT];
    logic [7:0] m_svc   [NSLOT];
    logic [7:0] m_used  [NSLOT];
    logic       m_loaded[NSLOT];
    logic [11:0] m_now;
    logic [2:0] m_cur;
    logic       m_busy;
    logic [7:0] m_slice;
    logic [2:0] m_fifo  [NSLOT];
    logic [2:0] m_head;
    logic [3:0] m_cnt;
    logic       m_queued[NSLOT];

    function automatic bit runnable(int i);
        return m_loaded[i] && {4'd0, m_arr[i]} <= m_now && m_used[i] < m_svc[i];
    endfunction

    function automatic bit work_complete();
        for (int i = 0; i < NSLOT; i++)
            if (m_loaded[i] && m_used[i] < m_svc[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void ready_push(logic [2:0] s);
        if (m_queued[s] || m_cnt >= NSLOT) return;
        m_fifo[3'(m_head + m_cnt[2:0])] = s;
        m_queued[s] = 1'b1;
        m_cnt++;
    endfunction

    function automatic bit outranks(int i, int b);
        longint unsigned ni, nb;
        if (m_mode == cps_pkg::MODE_FCFS) return m_arr[i] < m_arr[b];
        if (m_mode == cps_pkg::MODE_SPN)  return m_svc[i] < m_svc[b];
        ni = longint'(m_now) - longint'(m_arr[i]) + longint'(m_svc[i]);
        nb = longint'(m_now) - longint'(m_arr[b]) + longint'(m_svc[b]);
        return ni * m_svc[b] > nb * m_svc[i];
    endfunction

    function automatic t_sched_res schedule_step(t_sched_cmd c);
        t_sched_res r;
        logic [7:0] q;
        logic [2:0] s;
        r = '{3'd0, 1'b1, 1'b0, 1'b0};
        if (c.cmd == cps_pkg::CMD_LOAD) begin
            m_arr[c.slot]    = c.arrival;
            m_svc[c.slot]    = c.service;
            m_used[c.slot]   = 8'd0;
            m_loaded[c.slot] = 1'b1;
            if (m_busy && m_cur == c.slot) m_busy = 1'b0;
        end else begin
            if (m_busy && !runnable(m_cur)) m_busy = 1'b0;
            if (m_mode == cps_pkg::MODE_RR) begin
                q = (m_quantum == 0) ? 8'd1 : m_quantum;
                for (int i = 0; i < NSLOT; i++)
                    if (runnable(i) && !(m_busy && i == m_cur)) ready_push(3'(i));
                if (m_busy && m_slice >= q) begin
                    ready_push(m_cur);
                    m_busy = 1'b0;
                end
                while (!m_busy && m_cnt > 0) begin
                    s = m_fifo[m_head];
                    m_head++;
                    m_cnt--;
                    m_queued[s] = 1'b0;
                    if (runnable(s)) begin
                        m_cur = s;
                        m_busy = 1'b1;
                        m_slice = 8'd0;
                    end
                end
            end else if (!m_busy) begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (runnable(i) && (!m_busy || outranks(i, m_cur))) begin
                        m_cur = 3'(i);
                        m_busy = 1'b1;
                    end
                end
                m_slice = 8'd0;
            end
            if (m_busy) begin
                m_used[m_cur]++;
                if (m_slice < cps_pkg::SLICE_MAX) m_slice++;
                r.run_slot = m_cur;
                r.idle = 1'b0;
                if (m_used[m_cur] >= m_svc[m_cur]) begin
                    r.finished = 1'b1;
                    m_busy = 1'b0;
                end
            end
            if (m_now < cps_pkg::NOW_MAX) m_now++;
        end
        r.all_done = work_complete();
        return r;
    endfunction

    // ---------------- stimulus and checking ----------------
    t_sched_cmd pending_cmds[$];
    t_sched_res expected_res[$];
    t_sched_cmd cur_cmd;
    int         burst_left, gap_left;
    int         hold_cycles, rdy_style, rdy_timer;
    bit         hold_request;
    bit         failed;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_res.push_back(schedule_step(cur_cmd));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {5'd0, cur_cmd.service, cur_cmd.arrival, cur_cmd.slot};
                    i_s_axis_tuser <= cur_cmd.cmd;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                    burst_left--;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_sched_res got, exp_r;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_cycles = 0;
            rdy_timer = 0;
            rdy_style = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = '{o_m_axis_tdata[2:0], o_m_axis_tdata[3], o_m_axis_tdata[4],
                        o_m_axis_tdata[5]};
                if (expected_res.size() == 0) begin
                    $display("%0t: unexpected result word %h", $realtime, o_m_axis_tdata);
                    failed = 1'b1;
                end else begin
                    exp_r = expected_res.pop_front();
                    if (got.run_slot !== exp_r.run_slot) begin
                        $display("%0t: running_slot exp %0d got %0d", $realtime,
                                 exp_r.run_slot, got.run_slot);
                        failed = 1'b1;
                    end
                    if (got.idle !== exp_r.idle) begin
                        $display("%0t: idle exp %0b got %0b", $realtime, exp_r.idle, got.idle);
                        failed = 1'b1;
                    end
                    if (got.finished !== exp_r.finished) begin
                        $display("%0t: finished exp %0b got %0b", $realtime,
                                 exp_r.finished, got.finished);
                        failed = 1'b1;
                    end
                    if (got.all_done !== exp_r.all_done) begin
                        $display("%0t: all_done exp %0b got %0b", $realtime,
                                 exp_r.all_done, got.all_done);
                        failed = 1'b1;
                    end
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_request) begin
                hold_request = 1'b0;
                hold_cycles = 400;
            end
            if (rdy_timer <= 0) begin
                rdy_style = $urandom_range(0, 3);
                rdy_timer = $urandom_range(16, 200);
            end
            rdy_timer--;
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_m_axis_tready <= 1'b0;
            end else begin
                case (rdy_style)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_axis_tready <= rdy_timer[2];
                endcase
            end
        end
    end

    function automatic t_sched_cmd load_cmd(int s, int a, int v);
        return '{cps_pkg::CMD_LOAD, 3'(s), 8'(a), 8'(v)};
    endfunction

    function automatic t_sched_cmd tick_cmd();
        return '{cps_pkg::CMD_TICK, 3'($urandom), 8'($urandom), 8'($urandom)};
    endfunction

    task automatic drain();
        while (pending_cmds.size() > 0 || i_s_axis_tvalid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == cps_pkg::CFG_MODE) m_mode = cps_pkg::t_mode'(val[1:0]);
        else m_quantum = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random workloads: a few loads, then a random run of ticks, now and then a reload
    task automatic fill_random(int n_items, int tick_bias);
        int s, v, k;
        k = 0;
        while (k < n_items) begin
            repeat ($urandom_range(1, 4)) begin
                s = $urandom_range(0, NSLOT - 1);
                v = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255)
                                                : $urandom_range(1, 8);
                pending_cmds.push_back(load_cmd(s, $urandom_range(0, 255), v));
                k++;
            end
            repeat ($urandom_range(1, tick_bias)) begin
                pending_cmds.push_back(tick_cmd());
                k++;
            end
        end
    endtask

    initial begin
        failed = 1'b0;
        hold_request = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = cps_pkg::CFG_MODE;
        i_cfg_data = '0;
        m_mode = cps_pkg::MODE_FCFS;
        m_quantum = 8'd1;
        m_now = '0;
        m_cur = '0;
        m_busy = 1'b0;
        m_slice = '0;
        m_head = '0;
        m_cnt = '0;
        for (int i = 0; i < NSLOT; i++) begin
            m_used[i] = '0;
            m_loaded[i] = 1'b0;
            m_queued[i] = 1'b0;
            m_arr[i] = '0;
            m_svc[i] = '0;
            m_fifo[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty tick, extremes, reload of the running slot, late arrival
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(load_cmd(7, 255, 1));
        pending_cmds.push_back(load_cmd(0, 0, 255));
        pending_cmds.push_back(load_cmd(3, 1, 2));
        repeat (3) pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(load_cmd(0, 0, 1));
        repeat (3) pending_cmds.push_back(tick_cmd());
        drain();
        write_reg(cps_pkg::CFG_MODE, cps_pkg::MODE_RR);
        write_reg(cps_pkg::CFG_QUANTUM, 8'd1);
        pending_cmds.push_back(load_cmd(1, 0, 3));
        pending_cmds.push_back(load_cmd(2, 0, 2));
        pending_cmds.push_back(load_cmd(5, 2, 1));
        repeat (7) pending_cmds.push_back(tick_cmd());
        drain();

        write_reg(cps_pkg::CFG_QUANTUM, 8'd255);
        fill_random(150, 30);
        hold_request = 1'b1;
        drain();
        // mode change while a process is on the CPU
        pending_cmds.push_back(load_cmd(4, 0, 6));
        repeat (2) pending_cmds.push_back(tick_cmd());
        drain();
        write_reg(cps_pkg::CFG_MODE, cps_pkg::MODE_SPN);
        fill_random(180, 25);
        drain();
        write_reg(cps_pkg::CFG_MODE, cps_pkg::MODE_HRRN);
        fill_random(180, 25);
        drain();
        write_reg(cps_pkg::CFG_MODE, cps_pkg::MODE_RR);
        write_reg(cps_pkg::CFG_QUANTUM, 8'd3);
        fill_random(180, 25);
        drain();
        write_reg(cps_pkg::CFG_MODE, cps_pkg::MODE_FCFS);
        fill_random(150, 25);
        drain();
        write_reg(cps_pkg::CFG_MODE, cps_pkg::MODE_RR);
        write_reg(cps_pkg::CFG_QUANTUM, 8'd2);
        fill_random(150, 20);
        drain();
        // final HRRN run with longer tick stretches
        write_reg(cps_pkg::CFG_MODE, cps_pkg::MODE_HRRN);
        fill_random(100, 40);
        drain();
        repeat (60) @(posedge i_clk);

        if (!failed && expected_res.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/cps_pkg.sv
rtl/core/cpu_process_scheduler_unit.sv
bench/tb_cpu_process_scheduler_unit.sv
